FILE: rtl/kcsd_pkg.sv
// Shared types, constants and the constant rule table of the keypad combo detector.
`timescale 1ns / 1ps
`default_nettype none
package kcsd_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_KEYS_DEF   = 16;
  localparam int NUM_RULES_DEF  = 44;
  localparam int NUM_STATES_DEF = 37;

  // Size of the rule table and of the per-state start table
  localparam int RULE_COUNT  = 44;
  localparam int START_COUNT = 37;
  localparam int RULE_IDX_W  = $clog2(RULE_COUNT);
  localparam int RULE_CNT_W  = $clog2(RULE_COUNT + 1);

  // Field widths
  localparam int KEY_W   = 16;
  localparam int STATE_W = 6;
  localparam int CODE_W  = 4;

  // Key test encoding inside a rule
  localparam logic [7:0] TEST_FIELD = 8'hf0;
  localparam logic [7:0] KEY_FIELD  = 8'h0f;
  localparam logic [7:0] TEST_DOWN  = 8'h10;
  localparam logic [7:0] TEST_UP    = 8'h20;

  // Chord of keys 8..11
  localparam logic [KEY_W-1:0] CHORD_B_MASK = 16'h0f00;
  localparam logic [KEY_W-1:0] ONE_KEY      = 16'h0001;

  // Combo codes
  localparam logic [CODE_W-1:0] CODE_NONE      = 4'd0;
  localparam logic [CODE_W-1:0] CODE_B_DOWN    = 4'd2;
  localparam logic [CODE_W-1:0] CODE_E_DOWN    = 4'd5;
  localparam logic [CODE_W-1:0] RELEASE_OFFSET = 4'd5;

  // State record kept in the state memory
  typedef struct packed {
    logic [STATE_W-1:0] seq_state;
    logic [CODE_W-1:0]  last_action;
    logic [KEY_W-1:0]   release_key_bit;
  } state_rec_t;

  localparam int STATE_REC_W = $bits(state_rec_t);
  localparam int STATE_DEPTH = 1;

  // One rule of the table
  typedef struct packed {
    logic [STATE_W-1:0] st;
    logic [7:0]         keytest;
    logic [STATE_W-1:0] next;
    logic [CODE_W-1:0]  act;
  } rule_t;

  // Write side of the state memory
  typedef struct packed {
    logic       we;
    state_rec_t data;
  } rec_wr_t;

  // Finished word handed to the output register
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } result_t;

  // First rule of each state
  function automatic logic [RULE_IDX_W-1:0] first_rule(input logic [STATE_W-1:0] s);
    logic [RULE_IDX_W-1:0] r;
    r = '0;
    case (s)
      6'd0:  r = 6'd0;   6'd1:  r = 6'd4;   6'd2:  r = 6'd5;   6'd3:  r = 6'd6;
      6'd4:  r = 6'd7;   6'd5:  r = 6'd8;   6'd6:  r = 6'd9;   6'd7:  r = 6'd10;
      6'd8:  r = 6'd11;  6'd9:  r = 6'd12;  6'd10: r = 6'd13;  6'd11: r = 6'd14;
      6'd12: r = 6'd16;  6'd13: r = 6'd17;  6'd14: r = 6'd18;  6'd15: r = 6'd19;
      6'd16: r = 6'd20;  6'd17: r = 6'd21;  6'd18: r = 6'd22;  6'd19: r = 6'd23;
      6'd20: r = 6'd24;  6'd21: r = 6'd25;  6'd22: r = 6'd26;  6'd23: r = 6'd27;
      6'd24: r = 6'd28;  6'd25: r = 6'd29;  6'd26: r = 6'd30;  6'd27: r = 6'd32;
      6'd28: r = 6'd33;  6'd29: r = 6'd34;  6'd30: r = 6'd35;  6'd31: r = 6'd36;
      6'd32: r = 6'd38;  6'd33: r = 6'd39;  6'd34: r = 6'd41;  6'd35: r = 6'd42;
      6'd36: r = 6'd43;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rule_t mk(input int st, input int key, input logic [7:0] test,
                               input int nx, input int act);
    rule_t r;
    r.st      = STATE_W'(st);
    r.keytest = (8'(key) & KEY_FIELD) | test;
    r.next    = STATE_W'(nx);
    r.act     = CODE_W'(act);
    return r;
  endfunction

  // Rule table, in scan order
  function automatic rule_t rule_at(input logic [RULE_IDX_W-1:0] i);
    rule_t r;
    r = '0;
    case (i)
      6'd0:  r = mk(0, 12, TEST_DOWN, 1, 0);
      6'd1:  r = mk(0, 9, TEST_DOWN, 5, 0);
      6'd2:  r = mk(0, 8, TEST_DOWN, 9, 0);
      6'd3:  r = mk(0, 4, TEST_DOWN, 18, 0);
      6'd4:  r = mk(1, 13, TEST_DOWN, 2, 0);
      6'd5:  r = mk(2, 14, TEST_DOWN, 3, 0);
      6'd6:  r = mk(3, 15, TEST_DOWN, 4, 1);
      6'd7:  r = mk(4, 15, TEST_UP, 0, 6);
      6'd8:  r = mk(5, 10, TEST_DOWN, 6, 0);
      6'd9:  r = mk(6, 5, TEST_DOWN, 7, 0);
      6'd10: r = mk(7, 6, TEST_DOWN, 8, 3);
      6'd11: r = mk(8, 6, TEST_UP, 0, 8);
      6'd12: r = mk(9, 8, TEST_UP, 10, 0);
      6'd13: r = mk(10, 9, TEST_DOWN, 11, 0);
      6'd14: r = mk(11, 9, TEST_UP, 12, 0);
      6'd15: r = mk(11, 10, TEST_DOWN, 6, 0);
      6'd16: r = mk(12, 10, TEST_DOWN, 13, 0);
      6'd17: r = mk(13, 10, TEST_UP, 14, 0);
      6'd18: r = mk(14, 10, TEST_DOWN, 15, 0);
      6'd19: r = mk(15, 10, TEST_UP, 16, 0);
      6'd20: r = mk(16, 11, TEST_DOWN, 17, 4);
      6'd21: r = mk(17, 11, TEST_UP, 0, 9);
      6'd22: r = mk(18, 4, TEST_UP, 19, 0);
      6'd23: r = mk(19, 4, TEST_DOWN, 20, 0);
      6'd24: r = mk(20, 4, TEST_UP, 21, 0);
      6'd25: r = mk(21, 12, TEST_DOWN, 22, 0);
      6'd26: r = mk(22, 12, TEST_UP, 23, 0);
      6'd27: r = mk(23, 12, TEST_DOWN, 24, 0);
      6'd28: r = mk(24, 12, TEST_UP, 25, 0);
      6'd29: r = mk(25, 8, TEST_DOWN, 26, 0);
      6'd30: r = mk(26, 8, TEST_UP, 27, 0);
      6'd31: r = mk(26, 10, TEST_DOWN, 6, 0);
      6'd32: r = mk(27, 9, TEST_DOWN, 28, 0);
      6'd33: r = mk(28, 9, TEST_UP, 29, 0);
      6'd34: r = mk(29, 8, TEST_DOWN, 30, 0);
      6'd35: r = mk(30, 8, TEST_UP, 31, 0);
      6'd36: r = mk(31, 9, TEST_DOWN, 32, 0);
      6'd37: r = mk(31, 10, TEST_DOWN, 13, 0);
      6'd38: r = mk(32, 9, TEST_UP, 33, 0);
      6'd39: r = mk(33, 11, TEST_DOWN, 34, 0);
      6'd40: r = mk(33, 9, TEST_DOWN, 11, 0);
      6'd41: r = mk(34, 11, TEST_UP, 35, 0);
      6'd42: r = mk(35, 10, TEST_DOWN, 36, 5);
      6'd43: r = mk(36, 10, TEST_UP, 0, 10);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Lowest set bit of a key mask
  function automatic logic [KEY_W-1:0] lowest_bit(input logic [KEY_W-1:0] v);
    return v & (~v + ONE_KEY);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kcsd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module kcsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kcsd_seq.sv
// Per-word sequencer: reads the state record, checks fast paths, scans rules, writes back.
`timescale 1ns / 1ps
`default_nettype none
module kcsd_seq #(
  parameter int NUM_KEYS   = kcsd_pkg::NUM_KEYS_DEF,
  parameter int NUM_RULES  = kcsd_pkg::NUM_RULES_DEF,
  parameter int NUM_STATES = kcsd_pkg::NUM_STATES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kcsd_pkg::KEY_W-1:0]    pressed_mask,
  input  wire logic [kcsd_pkg::KEY_W-1:0]    released_mask,
  input  wire logic [kcsd_pkg::KEY_W-1:0]    held_mask,
  output logic                               rec_rd,
  input  wire kcsd_pkg::state_rec_t          rec_rdata,
  output kcsd_pkg::rec_wr_t                  rec_wr,
  input  wire logic                          out_free,
  output kcsd_pkg::result_t                  result
);

  localparam int KW = kcsd_pkg::KEY_W;
  localparam int CW = kcsd_pkg::CODE_W;
  localparam int SW = kcsd_pkg::STATE_W;
  localparam int NW = kcsd_pkg::RULE_CNT_W;
  localparam int SCAN_END  = (NUM_RULES < kcsd_pkg::RULE_COUNT) ? NUM_RULES
                                                                 : kcsd_pkg::RULE_COUNT;
  localparam int STATE_END = (NUM_STATES < kcsd_pkg::START_COUNT) ? NUM_STATES
                                                                   : kcsd_pkg::START_COUNT;
  localparam logic [NW-1:0] SCAN_END_V  = NW'(SCAN_END);
  localparam logic [SW:0]   STATE_END_V = (SW + 1)'(STATE_END);
  localparam logic [KW-1:0] KEY_MASK    = KW'((17'd1 << NUM_KEYS) - 17'd1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           fsm, fsm_next;
  logic [KW-1:0]        down, up, held;
  kcsd_pkg::state_rec_t rec, rec_next;
  logic [CW-1:0]        code, code_next;
  logic [NW-1:0]        idx, idx_next;

  kcsd_pkg::rule_t      rule;
  logic [7:0]           rule_test;
  logic [KW-1:0]        rule_bit;
  logic [KW-1:0]        rule_mask;
  logic                 rule_in_state;
  logic                 rule_hit;
  logic [KW-1:0]        down_low;

  assign in_stall = (fsm != S_IDLE);
  // The state record has one entry; the read is launched with the accepted word
  assign rec_rd   = in_valid && (fsm == S_IDLE);
  assign down_low = kcsd_pkg::lowest_bit(down);

  // Current rule and its key test
  always_comb begin
    rule          = kcsd_pkg::rule_at(idx[kcsd_pkg::RULE_IDX_W-1:0]);
    rule_test     = rule.keytest & kcsd_pkg::TEST_FIELD;
    rule_bit      = kcsd_pkg::ONE_KEY << rule.keytest[3:0];
    if (rule_test == kcsd_pkg::TEST_DOWN) begin
      rule_mask = down;
    end else if (rule_test == kcsd_pkg::TEST_UP) begin
      rule_mask = up;
    end else begin
      rule_mask = held;
    end
    rule_in_state = (idx < SCAN_END_V) && (rule.st == rec.seq_state);
    rule_hit      = (rule_mask & rule_bit) != '0;
  end

  // Sequencer
  always_comb begin
    fsm_next  = fsm;
    rec_next  = rec;
    code_next = code;
    idx_next  = idx;
    rec_wr    = '0;
    result    = '0;
    unique case (fsm)
      S_IDLE: begin
        if (in_valid) begin
          fsm_next = S_EVAL;
        end
      end
      S_EVAL: begin
        rec_next  = rec_rdata;
        code_next = kcsd_pkg::CODE_NONE;
        fsm_next  = S_DONE;
        if (down == '0 && up == '0) begin
          // quiet scan: no change
        end else if (held == kcsd_pkg::CHORD_B_MASK &&
                     rec_rdata.last_action != kcsd_pkg::CODE_B_DOWN) begin
          // chord of keys 8..11
          if (down_low == '0) begin
            rec_next.last_action = kcsd_pkg::CODE_NONE;
          end else begin
            rec_next.release_key_bit = down_low;
            rec_next.last_action     = kcsd_pkg::CODE_B_DOWN;
            code_next                = kcsd_pkg::CODE_B_DOWN;
          end
        end else if (rec_rdata.last_action != kcsd_pkg::CODE_NONE &&
                     rec_rdata.last_action <= kcsd_pkg::CODE_E_DOWN) begin
          // combo down: watch its release key
          if ((held & rec_rdata.release_key_bit) == '0) begin
            rec_next.seq_state   = '0;
            rec_next.last_action = rec_rdata.last_action + kcsd_pkg::RELEASE_OFFSET;
            code_next            = rec_rdata.last_action + kcsd_pkg::RELEASE_OFFSET;
          end
        end else if ({1'b0, rec_rdata.seq_state} < STATE_END_V) begin
          idx_next = NW'(kcsd_pkg::first_rule(rec_rdata.seq_state));
          fsm_next = S_SCAN;
        end else begin
          // state with no rules
          rec_next.seq_state   = '0;
          rec_next.last_action = kcsd_pkg::CODE_NONE;
        end
      end
      S_SCAN: begin
        if (!rule_in_state || rule_hit) begin
          fsm_next = S_DONE;
          if (rule_in_state) begin
            rec_next.seq_state   = rule.next;
            rec_next.last_action = rule.act;
            code_next            = rule.act;
            if (rule.act != kcsd_pkg::CODE_NONE) begin
              rec_next.release_key_bit = down_low;
            end
          end else begin
            rec_next.seq_state   = '0;
            rec_next.last_action = kcsd_pkg::CODE_NONE;
            code_next            = kcsd_pkg::CODE_NONE;
          end
        end else begin
          idx_next = idx + NW'(1);
        end
      end
      S_DONE: begin
        // write back and hand over the result together
        if (out_free) begin
          rec_wr.we    = 1'b1;
          rec_wr.data  = rec;
          result.valid = 1'b1;
          result.code  = code;
          fsm_next     = S_IDLE;
        end
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (fsm == S_IDLE && in_valid) begin
      down <= pressed_mask & KEY_MASK;
      up   <= released_mask & KEY_MASK;
      held <= held_mask & KEY_MASK;
    end
    rec  <= rec_next;
    code <= code_next;
    idx  <= idx_next;
  end

endmodule
`default_nettype wire

FILE: rtl/keypad_combo_sequence_detector_top.sv
// Top level of the keypad combo sequence detector: state memory, sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none
// Takes one keypad scan word (pressed, released and held key masks) and answers each with
// one combo code: 0 for none, 1..5 for combos A..E going down, 6..10 for their release.
// The sequence state, last action and release key live in a one-entry state memory that
// is read when a word is accepted and written back when its result is handed over; only
// one word is in flight, so read and write never overlap. A fast path (quiet scan, chord,
// combo held or released, state with no rules) decides a word without a rule scan;
// otherwise the rule table is walked one rule per cycle, and when no rule matches the
// slot that ends the state's rules is looked at as well. At most four rules for a state
// here. The result sits in an output register; a stalled result holds back the next
// word's write-back, not its evaluation.
module keypad_combo_sequence_detector_top #(
  parameter int NUM_KEYS   = kcsd_pkg::NUM_KEYS_DEF,
  parameter int NUM_RULES  = kcsd_pkg::NUM_RULES_DEF,
  parameter int NUM_STATES = kcsd_pkg::NUM_STATES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kcsd_pkg::KEY_W-1:0]    pressed_mask,
  input  wire logic [kcsd_pkg::KEY_W-1:0]    released_mask,
  input  wire logic [kcsd_pkg::KEY_W-1:0]    held_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [kcsd_pkg::CODE_W-1:0]        combo_code
);

  localparam int AW = (kcsd_pkg::STATE_DEPTH > 1) ? $clog2(kcsd_pkg::STATE_DEPTH) : 1;

  logic                                rec_rd;
  logic [kcsd_pkg::STATE_REC_W-1:0]    ram_rdata;
  kcsd_pkg::state_rec_t                rec_rdata;
  kcsd_pkg::rec_wr_t                   rec_wr;
  kcsd_pkg::result_t                   result;
  logic                                rec_valid;
  logic                                out_free;

  // State memory
  kcsd_ram #(
    .WIDTH (kcsd_pkg::STATE_REC_W),
    .DEPTH (kcsd_pkg::STATE_DEPTH),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (rec_wr.we),
    .waddr ('0),
    .wdata (rec_wr.data),
    .re    (rec_rd),
    .raddr ('0),
    .rdata (ram_rdata)
  );

  // Entry reads as zero until first written after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (rec_wr.we) begin
      rec_valid <= 1'b1;
    end
  end

  assign rec_rdata = rec_valid ? kcsd_pkg::state_rec_t'(ram_rdata) : '0;
  assign out_free  = !out_valid || !out_stall;

  kcsd_seq #(
    .NUM_KEYS   (NUM_KEYS),
    .NUM_RULES  (NUM_RULES),
    .NUM_STATES (NUM_STATES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pressed_mask  (pressed_mask),
    .released_mask (released_mask),
    .held_mask     (held_mask),
    .rec_rd        (rec_rd),
    .rec_rdata     (rec_rdata),
    .rec_wr        (rec_wr),
    .out_free      (out_free),
    .result        (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      combo_code <= result.code;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kcsd_checker.sv
// Port-level checker for the keypad combo detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kcsd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [kcsd_pkg::CODE_W-1:0] combo_code
);

  localparam logic [kcsd_pkg::CODE_W-1:0] CODE_MAX = 4'd10;

  // Codes never go past combo E release
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> combo_code <= CODE_MAX)
    else $error("combo code out of range");

  // One word at a time: an accepted word blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  // A new result only appears while the input side is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(in_stall))
    else $error("result without a word in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(combo_code)))
    else $error("stalled result changed");

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keypad_combo_sequence_detector_top kcsd_checker u_kcsd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .combo_code (combo_code)
);
`default_nettype wire
